### design/pse_pkg.sv
package pse_pkg;

    // Record kinds carried on the output.
    localparam logic REC_PROGRAM = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    // Shortest section that holds a header and a CRC.
    localparam logic [11:0] MIN_LENGTH = 12'd9;

    // Record queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Header walk of one section.
    typedef enum logic [1:0] {
        HDR_IDLE,
        HDR_LEN_HI,
        HDR_LEN_LO,
        HDR_BODY
    } t_hdr;

    // One result word.
    typedef struct packed {
        logic        record_kind;
        logic [7:0]  table_id;
        logic [11:0] section_length;
        logic [15:0] program_number;
        logic [12:0] pmt_pid;
        logic [9:0]  pid_count;
        logic        malformed;
    } t_rec;

    // Parser to queue push.
    typedef struct packed {
        logic push;
        t_rec rec;
    } t_push;

endpackage

### design/pse_front.sv
module pse_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_section_byte,
    input  logic          i_first_byte,
    output pse_pkg::t_push o_push,
    input  logic          i_full
);
    import pse_pkg::*;

    t_hdr        r_hdr,   n_hdr;
    logic [11:0] r_pos,   n_pos;
    logic [7:0]  r_tid,   n_tid;
    logic [11:0] r_len,   n_len;
    logic [23:0] r_entry, n_entry;
    logic [9:0]  r_count, n_count;

    logic        w_accept;
    logic [11:0] w_k;
    logic [11:0] w_len_full;
    logic [12:0] w_k_plus4;
    logic        w_in_entry;

    // A word is taken whenever the queue has room.
    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;

    assign w_k        = r_pos + 12'd1;
    assign w_len_full = {r_len[11:8], i_section_byte};
    assign w_k_plus4  = {1'b0, w_k} + 13'd4;

    // Last byte of a complete entry that lies before the CRC region.
    assign w_in_entry = (r_len >= MIN_LENGTH) && (w_k >= 12'd9)
                        && (w_k_plus4 <= {1'b0, r_len}) && (w_k[1:0] == 2'd1);

    // Header walk, entry gathering and record forming.
    always_comb begin
        n_hdr   = r_hdr;
        n_pos   = r_pos;
        n_tid   = r_tid;
        n_len   = r_len;
        n_entry = r_entry;
        n_count = r_count;
        o_push  = '0;
        o_push.rec.table_id       = r_tid;
        o_push.rec.section_length = r_len;
        if (w_accept) begin
            if (i_first_byte) begin
                n_hdr   = HDR_LEN_HI;
                n_pos   = '0;
                n_tid   = i_section_byte;
                n_len   = '0;
                n_entry = '0;
                n_count = '0;
            end else begin
                unique case (r_hdr)
                    HDR_IDLE: begin
                    end
                    HDR_LEN_HI: begin
                        n_len = {i_section_byte[3:0], 8'd0};
                        n_hdr = HDR_LEN_LO;
                    end
                    HDR_LEN_LO: begin
                        n_len = w_len_full;
                        n_hdr = HDR_BODY;
                        if (w_len_full == 12'd0) begin
                            // Empty section closes at once.
                            n_hdr                     = HDR_IDLE;
                            o_push.push               = 1'b1;
                            o_push.rec.record_kind    = REC_SUMMARY;
                            o_push.rec.section_length = 12'd0;
                            o_push.rec.pid_count      = r_count;
                            o_push.rec.malformed      = 1'b1;
                        end
                    end
                    HDR_BODY: begin
                        n_pos   = w_k;
                        n_entry = {r_entry[15:0], i_section_byte};
                        if (w_in_entry && (r_entry[23:8] != 16'd0)) begin
                            o_push.push               = 1'b1;
                            o_push.rec.record_kind    = REC_PROGRAM;
                            o_push.rec.program_number = r_entry[23:8];
                            o_push.rec.pmt_pid        = {r_entry[4:0], i_section_byte};
                            if (r_count != 10'h3FF) begin
                                n_count = r_count + 10'd1;
                            end
                        end
                        if (w_k == r_len) begin
                            n_hdr                  = HDR_IDLE;
                            o_push.push            = 1'b1;
                            o_push.rec.record_kind = REC_SUMMARY;
                            o_push.rec.pid_count   = r_count;
                            o_push.rec.malformed   = (r_len < MIN_LENGTH);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= HDR_IDLE;
            r_pos   <= '0;
            r_tid   <= '0;
            r_len   <= '0;
            r_entry <= '0;
            r_count <= '0;
        end else begin
            r_hdr   <= n_hdr;
            r_pos   <= n_pos;
            r_tid   <= n_tid;
            r_len   <= n_len;
            r_entry <= n_entry;
            r_count <= n_count;
        end
    end

endmodule

### design/pse_queue.sv
module pse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pse_pkg::t_push i_push,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output pse_pkg::t_rec  o_rec
);
    import pse_pkg::*;

    t_rec              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_fill;
    logic              w_wr, w_rd;

    assign o_full  = (r_fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign w_wr    = i_push.push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    // Storage for queued records.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_push.rec;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

### design/pse_back.sv
module pse_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  pse_pkg::t_rec i_rec,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output pse_pkg::t_rec o_rec
);
    import pse_pkg::*;

    logic r_valid;
    t_rec r_rec;

    // Load the output register when it is free or being taken.
    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

endmodule

### design/pat_section_pid_extractor.sv
// A result word passes through the record queue and then the output register.
// Throughput: one section byte per cycle while o_stall is low; at most one word per byte.
// A four-entry record queue sits between the byte parser and the output
// register, so input stalls only when that queue is full.
// Reset is synchronous and active low; it closes any open section.
module pat_section_pid_extractor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_section_byte,
    input  logic        i_first_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_record_kind,
    output logic [7:0]  o_table_id,
    output logic [11:0] o_section_length,
    output logic [15:0] o_program_number,
    output logic [12:0] o_pmt_pid,
    output logic [9:0]  o_pid_count,
    output logic        o_malformed
);
    import pse_pkg::*;

    t_push w_push;
    logic  w_full, w_empty, w_pop;
    t_rec  w_qrec, w_orec;

    pse_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_section_byte (i_section_byte),
        .i_first_byte   (i_first_byte),
        .o_push         (w_push),
        .i_full         (w_full)
    );

    pse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_rec   (w_qrec)
    );

    pse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_rec   (w_qrec),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rec   (w_orec)
    );

    // Output word fields.
    assign o_record_kind    = w_orec.record_kind;
    assign o_table_id       = w_orec.table_id;
    assign o_section_length = w_orec.section_length;
    assign o_program_number = w_orec.program_number;
    assign o_pmt_pid        = w_orec.pmt_pid;
    assign o_pid_count      = w_orec.pid_count;
    assign o_malformed      = w_orec.malformed;

endmodule
